/* src/dma_region_allow_table_defines.svh */
// assertion macros for the dma region allow table
`ifndef DMA_REGION_ALLOW_TABLE_DEFINES_SVH
`define DMA_REGION_ALLOW_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/dmaat_pkg.sv */
// shared types and constants for the dma region allow table
package dmaat_pkg;

  localparam int ENTRY_COUNT = 16;
  localparam int MASK_W      = 16;
  localparam int ADDR_W      = 44;
  localparam int SIZE_W      = 43;
  localparam int PAGE_W      = 32;
  localparam int PAGES_W     = 30;
  localparam int PAGE_SHIFT  = 12;
  localparam int IN_W        = 96;
  localparam int OUT_W       = 8;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NO_FREE = 2'd2
  } status_t;

  typedef enum logic {
    REG_PROTECTED_MASK = 1'b0,
    REG_FORMAT_VERSION = 1'b1
  } reg_idx_t;

  // request broadcast to every cell
  typedef struct packed {
    logic                 go;
    cmd_t                 cmd;
    logic                 add_ok;
    logic                 rm_ok;
    logic [PAGE_W-1:0]    page;
    logic [PAGES_W-1:0]   pages;
  } req_t;

endpackage

/* src/dmaat_cell.sv */
// one table entry with its used bit and priority claim link
module dmaat_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  dmaat_pkg::req_t  req,
  input  logic             prot,
  input  logic             claim_in,
  output logic             claim_out,
  output logic             hit
);
  import dmaat_pkg::*;

  logic [PAGE_W-1:0]  page_r,  page_nxt;
  logic [PAGES_W-1:0] pages_r, pages_nxt;
  logic               en_r,    en_nxt;
  logic               used_r,  used_nxt;
  logic               cand;

  // candidate for the pending command
  always_comb begin
    case (req.cmd)
      CMD_ADD:    cand = !prot && !used_r;
      CMD_REMOVE: cand = !prot && req.rm_ok && (page_r == req.page) &&
                         (pages_r == req.pages);
      default:    cand = 1'b0;
    endcase
  end

  // first candidate down the chain wins
  assign hit       = cand && !claim_in;
  assign claim_out = claim_in || cand;

  // entry update
  always_comb begin
    page_nxt  = page_r;
    pages_nxt = pages_r;
    en_nxt    = en_r;
    used_nxt  = used_r;
    if (req.go) begin
      case (req.cmd)
        CMD_ADD: begin
          if (hit && req.add_ok) begin
            page_nxt  = req.page;
            pages_nxt = req.pages;
            en_nxt    = 1'b1;
            used_nxt  = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (hit) begin
            page_nxt  = '0;
            pages_nxt = '0;
            en_nxt    = 1'b0;
            used_nxt  = 1'b0;
          end
        end
        CMD_CLEAR: begin
          if (!prot) begin
            page_nxt  = '0;
            pages_nxt = '0;
            en_nxt    = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r  <= '0;
      pages_r <= '0;
      en_r    <= 1'b0;
      used_r  <= 1'b0;
    end else begin
      page_r  <= page_nxt;
      pages_r <= pages_nxt;
      en_r    <= en_nxt;
      used_r  <= used_nxt;
    end
  end

endmodule

/* src/dma_region_allow_table.sv */
// top level of the dma region allow table
// Usage: commands arrive on the in_ stream (add, remove, clear all) and each
// produces exactly one result transaction on the out_ stream carrying a status
// and the entry index touched. The table is a row of 16 entry cells; a
// command is broadcast to all cells and a one-bit claim ripples down the row
// so the lowest matching or free cell takes it.
// A command accepted on in_ is latched in the request register, resolved by
// the cell row while held there and copied to the output register on commit.
// The single request register in front of the cell row takes no new command
// until the one it holds has committed.
// Configuration: cfg_ writes set the protected mask (index 0) and the format
// version (index 1); they are always accepted and are meant for idle periods.
// Reset: all entries zero and free, protected mask 0, format version 1.
// Stall: while a result waits on a low out_tready the pending command holds in
// the request register and in_tready stays low until the result is taken.
`include "dma_region_allow_table_defines.svh"

module dma_region_allow_table (
  input  logic        clk,
  input  logic        rst_n,
  // command, region_address, region_size (from bit 0 up), zero padded
  input  logic [95:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // status, entry_index (from bit 0 up), zero padded
  output logic [7:0]  out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import dmaat_pkg::*;

  logic [MASK_W-1:0]      prot_mask_r;
  logic                   fmt_r;
  logic                   a_valid_r;
  cmd_t                   a_cmd_r;
  logic [ADDR_W-1:0]      a_addr_r;
  logic [SIZE_W-1:0]      a_size_r;
  logic                   out_valid_r;
  status_t                out_status_r, out_status_nxt;
  logic [3:0]             out_index_r,  out_index_nxt;
  logic                   commit;
  logic                   aligned;
  req_t                   req;
  logic [ENTRY_COUNT-1:0] prot;
  logic [ENTRY_COUNT-1:0] hit;
  logic [ENTRY_COUNT:0]   claim;
  logic [3:0]             hit_idx;

  assign in_tready = !a_valid_r;
  assign cfg_ready = 1'b1;
  assign commit    = a_valid_r && (!out_valid_r || out_tready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prot_mask_r <= '0;
      fmt_r       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_PROTECTED_MASK: prot_mask_r <= cfg_data;
        REG_FORMAT_VERSION: fmt_r       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // request register in front of the cell row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      a_valid_r <= 1'b1;
    end else if (commit) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_cmd_r  <= cmd_t'(in_tdata[1:0]);
      a_addr_r <= in_tdata[45:2];
      a_size_r <= in_tdata[88:46];
    end
  end

  // argument checks and broadcast request
  assign aligned = (a_addr_r[PAGE_SHIFT-1:0] == '0) && (a_size_r[PAGE_SHIFT-1:0] == '0);

  always_comb begin
    req.go     = commit;
    req.cmd    = a_cmd_r;
    req.add_ok = aligned && (fmt_r ? (a_size_r[42] == 1'b0) : (a_size_r[42:36] == '0));
    req.rm_ok  = aligned && (a_size_r[42] == 1'b0);
    req.page   = a_addr_r[ADDR_W-1:PAGE_SHIFT];
    req.pages  = a_size_r[PAGE_SHIFT+PAGES_W-1:PAGE_SHIFT];
  end

  // row of entry cells linked by the claim chain
  assign claim[0] = 1'b0;

  for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
    if (g < MASK_W) begin : g_prot
      assign prot[g] = prot_mask_r[g];
    end else begin : g_open
      assign prot[g] = 1'b0;
    end

    dmaat_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req       (req),
      .prot      (prot[g]),
      .claim_in  (claim[g]),
      .claim_out (claim[g+1]),
      .hit       (hit[g])
    );
  end

  // encode the winning cell, index kept to four bits
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | 4'(i);
      end
    end
  end

  // result of the pending command
  always_comb begin
    out_status_nxt = ST_INVALID;
    out_index_nxt  = '0;
    case (a_cmd_r)
      CMD_ADD: begin
        if (!claim[ENTRY_COUNT]) begin
          out_status_nxt = ST_NO_FREE;
        end else if (req.add_ok) begin
          out_status_nxt = ST_OK;
          out_index_nxt  = hit_idx;
        end
      end
      CMD_REMOVE: begin
        if (claim[ENTRY_COUNT]) begin
          out_status_nxt = ST_OK;
          out_index_nxt  = hit_idx;
        end
      end
      CMD_CLEAR: out_status_nxt = ST_OK;
      default:   out_status_nxt = ST_INVALID;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= out_status_nxt;
      out_index_r  <= out_index_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_index_r, out_status_r};

  // checks
  `ASSERT_ALWAYS(a_one_winner, clk, rst_n, $onehot0(hit), "more than one cell claimed the command")
  `ASSERT_ALWAYS(a_prot_untouched, clk, rst_n, (hit & prot) == '0, "protected entry selected")
  `ASSERT_NEXT(a_commit_shows, clk, rst_n, commit, out_valid_r && !a_valid_r, "committed command lost its result")

endmodule

/* test/dma_region_allow_table_tb.sv */
// testbench for the dma region allow table: directed and random command streams checked against a predictor
`timescale 1ns / 1ps

module dma_region_allow_table_tb;
  import dmaat_pkg::*;

  typedef struct {
    status_t    st;
    logic [3:0] idx;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [95:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // predicted table contents and configuration
  logic [PAGE_W-1:0]  tbl_page [ENTRY_COUNT];
  logic [PAGES_W-1:0] tbl_pages [ENTRY_COUNT];
  logic               tbl_enabled [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] tbl_used;
  logic [MASK_W-1:0]  prot_mask;
  logic               fmt_v3;

  table_reply_t pending_replies[$];
  int err_count = 0;
  bit no_idle = 1'b0;
  int ready_hold = 0;

  dma_region_allow_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard limit on run time
  initial begin
    #5_000_000;
    $display("FAIL dma_region_allow_table");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  function automatic logic [30:0] region_page_limit();
    return fmt_v3 ? 31'h3FFF_FFFF : 31'h00FF_FFFF;
  endfunction

  function automatic void clear_table_model();
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      tbl_page[i] = '0;
      tbl_pages[i] = '0;
      tbl_enabled[i] = 1'b0;
    end
    tbl_used = '0;
    prot_mask = '0;
    fmt_v3 = 1'b1;
  endfunction

  // apply one command to the table model and queue the reply it gives
  function automatic void predict_table_reply(input cmd_t c, input logic [ADDR_W-1:0] a,
                                              input logic [SIZE_W-1:0] s);
    table_reply_t rep;
    logic [30:0] pg_cnt;
    bit done;
    rep.st = ST_INVALID;
    rep.idx = '0;
    done = 1'b0;
    pg_cnt = s[SIZE_W-1:PAGE_SHIFT];
    case (c)
      CMD_ADD: begin
        rep.st = ST_NO_FREE;
        for (int i = 0; i < ENTRY_COUNT; i++) begin
          if (!done && !prot_mask[i] && !tbl_used[i]) begin
            done = 1'b1;
            if (s[11:0] != 12'h000 || a[11:0] != 12'h000 || pg_cnt > region_page_limit()) begin
              rep.st = ST_INVALID;
            end else begin
              tbl_page[i] = a[ADDR_W-1:PAGE_SHIFT];
              tbl_pages[i] = pg_cnt[PAGES_W-1:0];
              tbl_enabled[i] = 1'b1;
              tbl_used[i] = 1'b1;
              rep.st = ST_OK;
              rep.idx = i[3:0];
            end
          end
        end
      end
      CMD_REMOVE: begin
        for (int i = 0; i < ENTRY_COUNT; i++) begin
          if (!done && !prot_mask[i] && {tbl_page[i], 12'h000} == a &&
              {1'b0, tbl_pages[i], 12'h000} == s) begin
            done = 1'b1;
            tbl_page[i] = '0;
            tbl_pages[i] = '0;
            tbl_enabled[i] = 1'b0;
            tbl_used[i] = 1'b0;
            rep.st = ST_OK;
            rep.idx = i[3:0];
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < ENTRY_COUNT; i++) begin
          if (!prot_mask[i]) begin
            tbl_page[i] = '0;
            tbl_pages[i] = '0;
            tbl_enabled[i] = 1'b0;
          end
        end
        rep.st = ST_OK;
      end
      default: rep.st = ST_INVALID;
    endcase
    pending_replies.push_back(rep);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one command; valid stays high after the transaction so a
  // back-to-back command follows without a dip
  task automatic send_cmd(input cmd_t c, input logic [ADDR_W-1:0] a,
                          input logic [SIZE_W-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {7'b0, s, a, c};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_table_reply(c, a, s);
  endtask

  // stop sending and wait until every reply has come back
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write both registers while the table is idle
  task automatic set_config(input logic [MASK_W-1:0] mask, input logic v3);
    cfg_index <= REG_PROTECTED_MASK;
    cfg_data <= mask;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    prot_mask = mask;
    cfg_index <= REG_FORMAT_VERSION;
    cfg_data <= {15'b0, v3};
    do @(posedge clk); while (!cfg_ready);
    fmt_v3 = v3;
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls and reply check
  always @(posedge clk) begin
    table_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply, status", int'(out_tdata[1:0]), -1);
      end else begin
        want = pending_replies.pop_front();
        if (out_tdata[1:0] != want.st)
          report_mismatch("status", int'(out_tdata[1:0]), int'(want.st));
        if (out_tdata[5:2] != want.idx)
          report_mismatch("entry_index", int'(out_tdata[5:2]), int'(want.idx));
      end
    end
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else if (no_idle || $urandom_range(0, 3) != 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      ready_hold = pick_gap();
    end
  end

  // argument checks, free zero entry match, unused command
  task automatic test_add_checks();
    send_cmd(CMD_REMOVE, 44'h0, 43'h0);
    send_cmd(CMD_ADD, 44'hFFF_FFFF_F000, {1'b0, 30'h3FFF_FFFF, 12'h000});
    send_cmd(CMD_ADD, 44'h001, 43'h1000);
    send_cmd(CMD_ADD, 44'h0, 43'h1);
    send_cmd(CMD_ADD, 44'h0, {31'h4000_0000, 12'h000});
    send_cmd(CMD_ADD, 44'h0, '1);
    send_cmd(CMD_ADD, 44'h0, 43'h0);
    send_cmd(CMD_REMOVE, 44'hFFF_FFFF_F000, {1'b0, 30'h3FFF_FFFF, 12'h000});
    send_cmd(CMD_REMOVE, 44'h1000, 43'h1000);
    send_cmd(CMD_RSVD, '1, '1);
    send_cmd(CMD_CLEAR, 44'h0, 43'h0);
    drain_replies();
  endtask

  // 24-bit page count limit, and removal of an entry stored under it
  task automatic test_format_select();
    set_config(16'h0000, 1'b0);
    send_cmd(CMD_ADD, 44'h5000, {7'b0, 24'hFF_FFFF, 12'h000});
    send_cmd(CMD_ADD, 44'h5000, {6'b0, 25'h100_0000, 12'h000});
    drain_replies();
    set_config(16'h0000, 1'b1);
    send_cmd(CMD_ADD, 44'h5000, {6'b0, 25'h100_0000, 12'h000});
    send_cmd(CMD_REMOVE, 44'h5000, {7'b0, 24'hFF_FFFF, 12'h000});
    drain_replies();
  endtask

  // protected entries, full table, clear all keeps the used map
  task automatic test_protect_and_clear();
    set_config(16'hFFFF, 1'b1);
    send_cmd(CMD_ADD, 44'h2000, 43'h1000);
    send_cmd(CMD_REMOVE, 44'h0, 43'h0);
    send_cmd(CMD_CLEAR, 44'h0, 43'h0);
    drain_replies();
    set_config(16'hFFF0, 1'b1);
    for (int i = 0; i < 5; i++)
      send_cmd(CMD_ADD, 44'h10000 + 44'(i << 12), 43'h3000);
    send_cmd(CMD_CLEAR, 44'h0, 43'h0);
    send_cmd(CMD_ADD, 44'h8000, 43'h1000);
    send_cmd(CMD_REMOVE, 44'h0, 43'h0);
    send_cmd(CMD_ADD, 44'h8000, 43'h1000);
    drain_replies();
  endtask

  task automatic send_random_cmd();
    int pick;
    int k;
    int live[$];
    logic [63:0] r;
    logic [63:0] r2;
    logic [30:0] pg;
    logic [ADDR_W-1:0] a;
    logic [SIZE_W-1:0] s;
    r = {$urandom(), $urandom()};
    r2 = {$urandom(), $urandom()};
    a = {r[43:12], 12'h000};
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      // well-formed add, half of them small regions
      if ($urandom_range(0, 1)) pg = 31'($urandom_range(0, 15));
      else pg = 31'($urandom() & region_page_limit());
      send_cmd(CMD_ADD, a, {pg, 12'h000});
    end else if (pick < 74) begin
      // remove of a stored region, now and then a protected or free one
      for (int i = 0; i < ENTRY_COUNT; i++)
        if (tbl_used[i] || $urandom_range(0, 7) == 0) live.push_back(i);
      if (live.size() == 0) begin
        send_cmd(CMD_REMOVE, a, 43'h0);
      end else begin
        k = live[$urandom_range(0, live.size() - 1)];
        a = {tbl_page[k], 12'h000};
        s = {1'b0, tbl_pages[k], 12'h000};
        // near miss on address or size
        if (pick >= 68) begin
          if (r2[0]) a = a ^ (44'h1000 << r2[5:1]);
          else s = s ^ (43'h1000 << r2[5:1]);
        end
        send_cmd(CMD_REMOVE, a, s);
      end
    end else if (pick < 82) begin
      send_cmd(CMD_ADD, r[43:0], r2[42:0]);
    end else if (pick < 88) begin
      // page count right at or one past the limit
      pg = 31'(region_page_limit() + $urandom_range(0, 1));
      send_cmd(CMD_ADD, a, {pg, 12'h000});
    end else if (pick < 93) begin
      send_cmd(CMD_CLEAR, r[43:0], r2[42:0]);
    end else begin
      send_cmd(cmd_t'($urandom_range(0, 3)), r[43:0], r2[42:0]);
    end
  endtask

  // random phases under several register settings
  task automatic test_random_traffic();
    logic [MASK_W-1:0] masks [6] = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFE, 16'h0000, 16'hFFFF};
    logic v3s [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    int counts [6] = '{250, 240, 240, 160, 240, 90};
    logic [MASK_W-1:0] m;
    for (int ph = 0; ph < 6; ph++) begin
      m = masks[ph];
      // random masks with only a few protected entries
      if (ph == 2 || ph == 4) m = MASK_W'($urandom() & $urandom() & $urandom());
      set_config(m, v3s[ph]);
      no_idle = (ph == 1);
      for (int n = 0; n < counts[ph]; n++) send_random_cmd();
      drain_replies();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_table_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_add_checks();
    test_format_select();
    test_protect_and_clear();
    test_random_traffic();
    drain_replies();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS dma_region_allow_table");
    end else begin
      $display("FAIL dma_region_allow_table");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/dmaat_pkg.sv
src/dmaat_cell.sv
src/dma_region_allow_table.sv
test/dma_region_allow_table_tb.sv
